@@ design/assert_macros.svh @@
// Assertion macros used by the semaphore core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("Assertion failed: same-cycle implication.");

`define ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("Assertion failed: next-cycle implication.");

`else

`define ASSERT_IMPLIES(label, clk, rstn, cond, expr)

`define ASSERT_NEXT(label, clk, rstn, cond, expr)

`endif

`endif

@@ design/csem_pkg.sv @@
`timescale 1ns / 1ps

package csem_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 8;
    localparam int COUNT_W         = 16;
    localparam int STATUS_W        = 3;
    localparam int OUT_DATA_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED   = 3'd0,
        STAT_QUEUED    = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_RELEASED  = 3'd3,
        STAT_SATURATED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DECIDE,
        S_HEAD,
        S_RELEASE,
        S_FINISH
    } state_t;

    localparam logic REQ_RELEASE = 1'b1;

endpackage

@@ design/counting_semaphore_wait_queue_core.sv @@
`timescale 1ns / 1ps
// Counting semaphore with an ordered queue of waiting thread ids.
// Requests arrive on the s_ stream: s_tuser is the request type (0 acquire,
// 1 release) and s_tdata the thread id. Each request gives one result item on
// the m_ stream: m_tuser is the status code, m_tdata carries the wake flag,
// the id to wake and the count after the request.
// The block takes one request at a time and is ready only while idle.
// A release reads the head of the wait queue to find the id to wake. An
// acquire walks the wait queue one slot per cycle through the single read port
// of the id memory, then closes the gap behind a matching entry one slot per
// cycle; when the queue is empty it skips the walk and goes straight to the
// grant decision. The block is ready again in the cycle after the result is
// loaded into the output register.
// A result waits in the output register while the receiver stalls, and the
// block holds its next result until that register is free.
// After reset, and after each write on the cfg_ channel, the count holds the
// written value (0 after reset) and the wait queue is empty.

`include "assert_macros.svh"

module counting_semaphore_wait_queue_core #(
    parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [csem_pkg::ID_W-1:0]       s_tdata,   // [7:0] thread_id
    input  logic                            s_tuser,   // [0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] wake_valid, [8:1] wake_id, [24:9] count_now, [31:25] zero
    output logic [csem_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [csem_pkg::STATUS_W-1:0]   m_tuser,   // [2:0] status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csem_pkg::COUNT_W-1:0]    cfg_data
);
    import csem_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
    localparam int PAD_W = OUT_DATA_W - 1 - ID_W - COUNT_W;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        idx_reg, idx_next;
    logic                 tag_vld_reg, tag_vld_next;
    logic [IW-1:0]        tag_reg, tag_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [ID_W-1:0]      rdata_reg;
    status_t              res_status_reg, res_status_next;
    logic                 res_wake_vld_reg, res_wake_vld_next;
    logic [ID_W-1:0]      res_wake_id_reg, res_wake_id_next;
    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    logic [ID_W-1:0]      mem [QUEUE_DEPTH];
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [ID_W-1:0]      wr_data;

    logic found;
    logic walk_done;
    logic idx_lt;
    logic out_free;
    logic load_out;
    logic cfg_write;
    logic count_upd;
    logic fill_upd;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign found     = tag_vld_reg && (rdata_reg == id_reg);
    assign idx_lt    = (idx_reg < fill_reg);
    assign walk_done = !tag_vld_reg && (idx_reg == fill_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == S_FINISH) && out_free;
    assign count_upd = cfg_write || (state_reg == S_DECIDE) || (state_reg == S_RELEASE);
    assign fill_upd  = cfg_write || (state_reg == S_DECIDE) || (state_reg == S_SHIFT);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_RELEASE) begin
                        state_next = S_HEAD;
                    end else if (fill_reg == '0) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    state_next = S_SHIFT;
                end else if (walk_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_SHIFT: begin
                if (walk_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:  state_next = S_FINISH;
            S_HEAD:    state_next = S_RELEASE;
            S_RELEASE: state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next        = count_reg;
        fill_next         = fill_reg;
        idx_next          = idx_reg;
        tag_vld_next      = tag_vld_reg;
        tag_next          = tag_reg;
        id_next           = id_reg;
        res_status_next   = res_status_reg;
        res_wake_vld_next = res_wake_vld_reg;
        res_wake_id_next  = res_wake_id_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = id_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next      = s_tdata;
                    idx_next     = '0;
                    tag_vld_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (found) begin
                    idx_next     = FW'(tag_reg) + FW'(1);
                    tag_vld_next = 1'b0;
                end else if (idx_lt) begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[IW-1:0];
                    tag_vld_next = 1'b1;
                    tag_next     = idx_reg[IW-1:0];
                    idx_next     = idx_reg + FW'(1);
                end else begin
                    tag_vld_next = 1'b0;
                end
            end
            S_SHIFT: begin
                if (idx_lt) begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[IW-1:0];
                    tag_vld_next = 1'b1;
                    tag_next     = idx_reg[IW-1:0];
                    idx_next     = idx_reg + FW'(1);
                end else begin
                    tag_vld_next = 1'b0;
                end
                if (tag_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = tag_reg - IW'(1);
                    wr_data = rdata_reg;
                end
                if (walk_done) begin
                    fill_next = fill_reg - FW'(1);
                end
            end
            S_DECIDE: begin
                res_wake_vld_next = 1'b0;
                res_wake_id_next  = '0;
                if (count_reg != '0) begin
                    count_next      = count_reg - COUNT_W'(1);
                    res_status_next = STAT_GRANTED;
                end else if (fill_reg != FILL_MAX) begin
                    wr_en           = 1'b1;
                    wr_addr         = fill_reg[IW-1:0];
                    wr_data         = id_reg;
                    fill_next       = fill_reg + FW'(1);
                    res_status_next = STAT_QUEUED;
                end else begin
                    res_status_next = STAT_FULL;
                end
            end
            S_HEAD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_RELEASE: begin
                res_wake_vld_next = (fill_reg != '0);
                res_wake_id_next  = (fill_reg != '0) ? rdata_reg : '0;
                if (count_reg == COUNT_MAX) begin
                    res_status_next = STAT_SATURATED;
                end else begin
                    count_next      = count_reg + COUNT_W'(1);
                    res_status_next = STAT_RELEASED;
                end
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
        if (cfg_write) begin
            count_next = cfg_data;
            fill_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            fill_reg     <= '0;
            tag_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            tag_vld_reg <= tag_vld_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        tag_reg          <= tag_next;
        id_reg           <= id_next;
        res_status_reg   <= res_status_next;
        res_wake_vld_reg <= res_wake_vld_next;
        res_wake_id_reg  <= res_wake_id_next;
        if (load_out) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, count_reg, res_wake_id_reg, res_wake_vld_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    `ASSERT_IMPLIES(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_MAX)
    `ASSERT_NEXT(a_count_hold, aclk, aresetn, !count_upd, $stable(count_reg))
    `ASSERT_NEXT(a_fill_hold, aclk, aresetn, !fill_upd, $stable(fill_reg))
    `ASSERT_IMPLIES(a_shift_in_range, aclk, aresetn, state_reg == S_SHIFT && wr_en, tag_reg != '0)

endmodule

@@ test/tb_counting_semaphore_wait_queue_core.sv @@
`timescale 1ns / 1ps

module tb_counting_semaphore_wait_queue_core;
    import csem_pkg::*;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam int   PHASES = 6;
    localparam int   PHASE_ITEMS = 235;
    localparam int   HOLD_CYCLES = 300;

    typedef struct packed {
        status_t              status;
        logic                 wake_valid;
        logic [ID_W-1:0]      wake_id;
        logic [COUNT_W-1:0]   count_now;
    } sem_result_t;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               req;
        logic [ID_W-1:0]    id;
        logic               known;
        sem_result_t        want;
        logic [COUNT_W-1:0] value;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [ID_W-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data;

    logic                  row_known;
    sem_result_t           row_expect;

    logic [COUNT_W-1:0]    sem_count;
    logic [ID_W-1:0]       waiter_id [QUEUE_DEPTH_DEF];
    logic [QUEUE_DEPTH_DEF-1:0] waiter_live;
    sem_result_t           pending_results[$];
    stim_row_t             directed[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    counting_semaphore_wait_queue_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic sem_result_t semaphore_step(logic req, logic [ID_W-1:0] id);
        sem_result_t r;
        int slot;
        r.status = STAT_GRANTED;
        r.wake_valid = 1'b0;
        r.wake_id = '0;
        if (req == REQ_ACQUIRE) begin
            slot = -1;
            for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
                if (slot < 0 && waiter_live[i] && waiter_id[i] == id) slot = i;
            if (slot >= 0) begin
                for (int j = slot; j < QUEUE_DEPTH_DEF - 1; j++) begin
                    waiter_id[j] = waiter_id[j+1];
                    waiter_live[j] = waiter_live[j+1];
                end
                waiter_live[QUEUE_DEPTH_DEF-1] = 1'b0;
            end
            if (sem_count != 0) begin
                sem_count = sem_count - 1'b1;
                r.status = STAT_GRANTED;
            end else begin
                slot = -1;
                for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
                    if (slot < 0 && !waiter_live[i]) slot = i;
                if (slot >= 0) begin
                    waiter_id[slot] = id;
                    waiter_live[slot] = 1'b1;
                    r.status = STAT_QUEUED;
                end else begin
                    r.status = STAT_FULL;
                end
            end
        end else begin
            if (waiter_live[0]) begin
                r.wake_valid = 1'b1;
                r.wake_id = waiter_id[0];
            end
            if (sem_count == COUNT_MAX) begin
                r.status = STAT_SATURATED;
            end else begin
                sem_count = sem_count + 1'b1;
                r.status = STAT_RELEASED;
            end
        end
        r.count_now = sem_count;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        sem_result_t want;
        sem_result_t predicted;
        if (!aresetn) begin
            sem_count = '0;
            waiter_live = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("wake_valid", want.wake_valid, m_tdata[0]);
                    check_field("wake_id", want.wake_id, m_tdata[8:1]);
                    check_field("count_now", want.count_now, m_tdata[24:9]);
                    check_field("padding", 0, m_tdata[31:25]);
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = semaphore_step(s_tuser, s_tdata);
                pending_results.push_back(row_known ? row_expect : predicted);
            end
            if (cfg_valid && cfg_ready) begin
                sem_count = cfg_data;
                waiter_live = '0;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic stim_row_t req_row(logic req, logic [ID_W-1:0] id);
        stim_row_t row;
        row.kind = ROW_REQUEST;
        row.req = req;
        row.id = id;
        row.known = 1'b0;
        row.want = '0;
        row.value = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(logic req, logic [ID_W-1:0] id, status_t status,
                                            logic wake_valid, logic [ID_W-1:0] wake_id,
                                            logic [COUNT_W-1:0] count_now);
        stim_row_t row;
        row = req_row(req, id);
        row.known = 1'b1;
        row.want.status = status;
        row.want.wake_valid = wake_valid;
        row.want.wake_id = wake_id;
        row.want.count_now = count_now;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [COUNT_W-1:0] value);
        stim_row_t row;
        row = req_row(REQ_ACQUIRE, '0);
        row.kind = ROW_CONFIG;
        row.value = value;
        return row;
    endfunction

    task automatic offer_request(logic req, logic [ID_W-1:0] id, logic known, sem_result_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= id;
        row_known <= known;
        row_expect <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [COUNT_W-1:0] phase_count [PHASES];
        logic               req;
        logic [ID_W-1:0]    id;
        sem_result_t        none;
        int                 acquire_pct;
        int                 drain_cycles;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        row_known = 1'b0;
        row_expect = '0;
        none = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Queue filled with 0xFF at the head, then ids 1 to 15 behind it.
        directed.push_back(cfg_row(16'd0));
        directed.push_back(known_row(REQ_RELEASE, 8'h00, STAT_RELEASED, 1'b0, 8'h00, 16'd1));
        directed.push_back(known_row(REQ_ACQUIRE, 8'hFF, STAT_GRANTED, 1'b0, 8'h00, 16'd0));
        directed.push_back(known_row(REQ_ACQUIRE, 8'h00, STAT_QUEUED, 1'b0, 8'h00, 16'd0));
        directed.push_back(known_row(REQ_RELEASE, 8'hAA, STAT_RELEASED, 1'b1, 8'h00, 16'd1));
        directed.push_back(known_row(REQ_ACQUIRE, 8'h00, STAT_GRANTED, 1'b0, 8'h00, 16'd0));
        directed.push_back(req_row(REQ_ACQUIRE, 8'hFF));
        for (int i = 1; i < QUEUE_DEPTH_DEF; i++)
            directed.push_back(req_row(REQ_ACQUIRE, 8'(i)));
        directed.push_back(known_row(REQ_ACQUIRE, 8'h80, STAT_FULL, 1'b0, 8'h00, 16'd0));
        directed.push_back(req_row(REQ_ACQUIRE, 8'h07));
        directed.push_back(req_row(REQ_RELEASE, 8'h55));
        directed.push_back(req_row(REQ_ACQUIRE, 8'hFF));
        directed.push_back(cfg_row(COUNT_MAX));
        directed.push_back(known_row(REQ_RELEASE, 8'h00, STAT_SATURATED, 1'b0, 8'h00, COUNT_MAX));
        directed.push_back(known_row(REQ_ACQUIRE, 8'h7F, STAT_GRANTED, 1'b0, 8'h00, 16'hFFFE));
        directed.push_back(known_row(REQ_RELEASE, 8'h01, STAT_RELEASED, 1'b0, 8'h00, COUNT_MAX));

        send_idle_pct = 29;
        recv_idle_pct = 65;
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CONFIG)
                write_count(directed[i].value);
            else
                offer_request(directed[i].req, directed[i].id, directed[i].known,
                              directed[i].want);
        end

        phase_count[0] = 16'd0;
        phase_count[1] = COUNT_MAX;
        phase_count[2] = 16'd1;
        phase_count[3] = 16'($urandom_range(65535));
        phase_count[4] = 16'd5;
        phase_count[5] = 16'hFFFE;
        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 65;
                end
                1: begin
                    send_idle_pct = 65;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_count(phase_count[p]);
            acquire_pct = (phase_count[p] > 16'd1000) ? 45 : 60;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p % 2 == 0 && k == 60)
                    hold_requests++;
                if (p == 3 && k == 120)
                    wait_drained();
                req = ($urandom_range(99) < acquire_pct) ? REQ_ACQUIRE : REQ_RELEASE;
                if ($urandom_range(4) == 0)
                    id = 8'($urandom_range(255));
                else
                    id = 8'($urandom_range(19));
                offer_request(req, id, 1'b0, none);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (80) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: expected %0d more results, actual 0", $time, pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ counting_semaphore_wait_queue_core.f @@
+incdir+design
design/csem_pkg.sv
design/counting_semaphore_wait_queue_core.sv
test/tb_counting_semaphore_wait_queue_core.sv
